// ----- hw/rtl/ssort_pkg.sv -----
// shared types, constants and command/status structs for the shell sort engine
package ssort_pkg;

	localparam int DEPTH_DEFAULT = 64;
	localparam int VALUE_W = 32;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      last_item;
	} sample_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      final_result;
		logic                      overflow;
	} result_t;

	typedef enum logic [2:0] {
		ST_COLLECT,
		ST_GAP_INIT,
		ST_POS,
		ST_HOLD,
		ST_CHECK,
		ST_CMP,
		ST_OUT_RD,
		ST_OUT_LD
	} ssort_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic store;     // write incoming value or mark drop
		logic gap_init;  // gap = count/2, pos = gap, out index = 0
		logic next_gap;  // gap = gap/2, pos = new gap
		logic rd_pos;    // read entry pos, slot = pos
		logic cap_held;  // latch read data as held value
		logic rd_prev;   // read entry slot-gap
		logic shift;     // move read entry up into slot, slot -= gap
		logic place;     // write held into slot, pos += 1
		logic rd_out;    // read entry at output index
		logic out_load;  // load result register, advance output index
	} ssort_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic half_zero;     // count/2 is zero
		logic gap_half_zero; // gap/2 is zero
		logic pos_end;       // pos reached count
		logic slot_ge_gap;
		logic held_less;     // held value below read value
		logic out_last;      // output index is the last element
		logic out_free;      // result register can take a value
	} ssort_stat_t;

endpackage

// ----- hw/rtl/ssort_dp.sv -----
// datapath: value store, sort counters, compare and result register
module ssort_dp #(
	parameter int DEPTH = ssort_pkg::DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ssort_pkg::VALUE_W-1:0] sample_value,
	input  ssort_pkg::ssort_cmd_t cmd,
	output ssort_pkg::ssort_stat_t stat,
	output logic                 result_valid,
	input  logic                 result_stall,
	output ssort_pkg::result_t   result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int VW = ssort_pkg::VALUE_W;

	logic [VW-1:0] mem [DEPTH];
	logic [VW-1:0] rdata_q;
	logic [VW-1:0] held_q;
	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [AW-1:0] gap_q;
	logic [CW-1:0] pos_q;
	logic [AW-1:0] slot_q;
	logic [AW-1:0] k_q;
	logic          out_valid_q;
	ssort_pkg::result_t out_q;

	logic          full;
	logic [AW-1:0] count_half;
	logic [AW-1:0] gap_half;
	logic [AW-1:0] prev_addr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [VW-1:0] wdata;
	logic          re;
	logic [AW-1:0] raddr;

	assign full       = (count_q == CW'(DEPTH));
	assign count_half = AW'(count_q >> 1);
	assign gap_half   = gap_q >> 1;
	assign prev_addr  = slot_q - gap_q;

	assign stat.half_zero     = (count_half == '0);
	assign stat.gap_half_zero = (gap_half == '0);
	assign stat.pos_end       = (pos_q >= count_q);
	assign stat.slot_ge_gap   = (slot_q >= gap_q);
	assign stat.held_less     = ($signed(held_q) < $signed(rdata_q));
	assign stat.out_last      = ((CW'(k_q) + CW'(1)) == count_q);
	assign stat.out_free      = !out_valid_q || !result_stall;

	// single write port
	always_comb begin
		we    = 1'b0;
		waddr = slot_q;
		wdata = held_q;
		if (cmd.store) begin
			we    = !full;
			waddr = count_q[AW-1:0];
			wdata = sample_value;
		end else if (cmd.shift) begin
			we    = 1'b1;
			wdata = rdata_q;
		end else if (cmd.place) begin
			we    = 1'b1;
		end
	end

	// single read port
	always_comb begin
		re    = cmd.rd_pos | cmd.rd_prev | cmd.rd_out;
		raddr = k_q;
		if (cmd.rd_pos) begin
			raddr = pos_q[AW-1:0];
		end else if (cmd.rd_prev) begin
			raddr = prev_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.store) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + CW'(1);
			end
		end else if (cmd.out_load && stat.out_last) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gap_init) begin
			gap_q <= count_half;
			pos_q <= CW'(count_half);
			k_q   <= '0;
		end
		if (cmd.next_gap) begin
			gap_q <= gap_half;
			pos_q <= CW'(gap_half);
		end
		if (cmd.rd_pos) begin
			slot_q <= pos_q[AW-1:0];
		end
		if (cmd.cap_held) begin
			held_q <= rdata_q;
		end
		if (cmd.shift) begin
			slot_q <= prev_addr;
		end
		if (cmd.place) begin
			pos_q <= pos_q + CW'(1);
		end
		if (cmd.out_load) begin
			k_q <= k_q + AW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.sorted_value <= rdata_q;
			out_q.final_result <= stat.out_last;
			out_q.overflow     <= dropped_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above store depth");

	a_store_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("stored item did not advance count");

	a_set_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && stat.out_last |=> count_q == '0 && !dropped_q)
		else $error("set not cleared after final result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result register overwritten while held");

endmodule

// ----- hw/rtl/ssort_ctrl.sv -----
// controller: collect, gapped insertion passes and result sequencing
module ssort_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	input  logic                  sample_last,
	output logic                  sample_stall,
	input  ssort_pkg::ssort_stat_t stat,
	output ssort_pkg::ssort_cmd_t  cmd
);

	ssort_pkg::ssort_state_t state_q;
	ssort_pkg::ssort_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssort_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ssort_pkg::ST_COLLECT: begin
				if (sample_valid && sample_last) begin
					state_d = ssort_pkg::ST_GAP_INIT;
				end
			end
			ssort_pkg::ST_GAP_INIT: begin
				state_d = stat.half_zero ? ssort_pkg::ST_OUT_RD : ssort_pkg::ST_POS;
			end
			ssort_pkg::ST_POS: begin
				if (!stat.pos_end) begin
					state_d = ssort_pkg::ST_HOLD;
				end else if (stat.gap_half_zero) begin
					state_d = ssort_pkg::ST_OUT_RD;
				end
			end
			ssort_pkg::ST_HOLD: begin
				state_d = ssort_pkg::ST_CHECK;
			end
			ssort_pkg::ST_CHECK: begin
				state_d = stat.slot_ge_gap ? ssort_pkg::ST_CMP : ssort_pkg::ST_POS;
			end
			ssort_pkg::ST_CMP: begin
				state_d = stat.held_less ? ssort_pkg::ST_CHECK : ssort_pkg::ST_POS;
			end
			ssort_pkg::ST_OUT_RD: begin
				state_d = ssort_pkg::ST_OUT_LD;
			end
			ssort_pkg::ST_OUT_LD: begin
				if (stat.out_free) begin
					state_d = stat.out_last ? ssort_pkg::ST_COLLECT : ssort_pkg::ST_OUT_RD;
				end
			end
			default: begin
				state_d = ssort_pkg::ST_COLLECT;
			end
		endcase
	end

	always_comb begin
		cmd          = '0;
		sample_stall = 1'b1;
		case (state_q)
			ssort_pkg::ST_COLLECT: begin
				sample_stall = 1'b0;
				cmd.store    = sample_valid;
			end
			ssort_pkg::ST_GAP_INIT: begin
				cmd.gap_init = 1'b1;
			end
			ssort_pkg::ST_POS: begin
				cmd.next_gap = stat.pos_end;
				cmd.rd_pos   = !stat.pos_end;
			end
			ssort_pkg::ST_HOLD: begin
				cmd.cap_held = 1'b1;
			end
			ssort_pkg::ST_CHECK: begin
				cmd.rd_prev = stat.slot_ge_gap;
				cmd.place   = !stat.slot_ge_gap;
			end
			ssort_pkg::ST_CMP: begin
				cmd.shift = stat.held_less;
				cmd.place = !stat.held_less;
			end
			ssort_pkg::ST_OUT_RD: begin
				cmd.rd_out = 1'b1;
			end
			ssort_pkg::ST_OUT_LD: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// a compare always follows a read of the entry one gap down
	a_cmp_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssort_pkg::ST_CMP |-> $past(state_q) == ssort_pkg::ST_CHECK)
		else $error("compare without preceding read");

	a_hold_after_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssort_pkg::ST_HOLD |-> $past(cmd.rd_pos))
		else $error("held value captured without read");

endmodule

// ----- hw/rtl/shell_sort_engine.sv -----
// top level of the shell sort engine
//
// Values arrive on the sample channel, one signed 32-bit value per transaction.
// A transaction with last_item set closes the set (its value belongs to it).
// Up to DEPTH values are kept; later ones are dropped and every result of
// that set then carries overflow.
// While collecting, a transaction is taken every cycle. After the last one the
// store is sorted ascending by Shell sort with halving gaps; each gapped
// insertion step captures the entry at pos as the held value, moves the
// entry one gap down up into the slot while the held value is below it,
// then writes the held value into the slot; the store has one read and one
// write port with registered read data. Results then leave on the result
// channel one at a time, each read from the store first; final_result marks
// the largest value. The sample channel stalls from the last transaction of a
// set until the final result is loaded into the result register. A stalled
// result holds its value, and the sequence waits for it.
// Reset clears the element count, the drop flag and the result valid; store
// contents need no clearing.
module shell_sort_engine #(
	parameter int DEPTH = ssort_pkg::DEPTH_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  ssort_pkg::sample_t sample,
	output logic               result_valid,
	input  logic               result_stall,
	output ssort_pkg::result_t result
);

	ssort_pkg::ssort_cmd_t  cmd;
	ssort_pkg::ssort_stat_t stat;

	ssort_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_last  (sample.last_item),
		.sample_stall (sample_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	ssort_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_value (sample.sample_value),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
